// File: design/crtc_pkg.sv
// package for the crt controller timing block: word types, codes, constants
package crtc_pkg;

    typedef enum logic [1:0] {
        REQ_SELECT = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] bus_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        hsync_out;
        logic        vsync_out;
        logic        display_enable;
        logic [13:0] mem_address;
        logic [5:0]  row_address;
        logic        cursor_blink;
    } out_word_t;

    localparam int NUM_REGS = 18;
    localparam logic [13:0] ADDR_MASK = 14'h3fff;
    localparam logic [7:0] R16_RESET = 8'h14;
    localparam logic [7:0] R17_RESET = 8'h7c;

    // register indexes with side effects
    localparam logic [4:0] R_HDISP  = 5'd1;
    localparam logic [4:0] R_VADJ   = 5'd5;
    localparam logic [4:0] R_VDISP  = 5'd6;
    localparam logic [4:0] R_VSPOS  = 5'd7;
    localparam logic [4:0] R_MODE   = 5'd8;
    localparam logic [4:0] R_MAXRAS = 5'd9;

    // per-register write mask
    function automatic logic [7:0] wr_mask(input logic [4:0] idx);
        logic [7:0] m;
        begin
            case (idx)
                5'd4, 5'd6, 5'd7, 5'd10: m = 8'h7f;
                5'd5, 5'd9, 5'd11:       m = 8'h1f;
                5'd8:                    m = 8'hf3;
                5'd12, 5'd14:            m = 8'h3f;
                default:                 m = 8'hff;
            endcase
            wr_mask = m;
        end
    endfunction

    // only R12..R17 read back
    function automatic logic readable(input logic [4:0] idx);
        readable = (idx >= 5'd12) && (idx <= 5'd17);
    endfunction

endpackage

// File: design/crtc_core.sv
// register file, counters and the one-word update logic
module crtc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  crtc_pkg::in_word_t  word,
    output crtc_pkg::out_word_t result
);
    import crtc_pkg::*;

    logic [7:0]  regs_reg [NUM_REGS];
    logic [7:0]  regs_next [NUM_REGS];
    logic [4:0]  sel_reg, sel_next;
    logic [7:0]  hc_reg, hc_next;
    logic [4:0]  rc_reg, rc_next;
    logic [6:0]  lc_reg, lc_next;
    logic [4:0]  adj_reg, adj_next;
    logic [13:0] ma_reg, ma_next, ls_reg, ls_next;
    logic [3:0]  hsc_reg, hsc_next, hsw_reg, hsw_next;
    logic [4:0]  vsc_reg, vsc_next, vsw_reg, vsw_next;
    logic f_htot_reg, f_htot_next, f_vtot_reg, f_vtot_next, f_mr_reg, f_mr_next;
    logic f_vadj_reg, f_vadj_next, f_vdisp_reg, f_vdisp_next, f_hdisp_reg, f_hdisp_next;
    logic f_r8dt_reg, f_r8dt_next, f_vscnt_reg, f_vscnt_next, f_hs_reg, f_hs_next;
    logic f_vs_reg, f_vs_next, f_ilace_reg, f_ilace_next;
    logic hlvs_reg, hlvs_next, par_reg, par_next, vsl_reg, vsl_next;
    logic [1:0] skew_reg, skew_next;
    logic [7:0] hds_reg, hds_next, hde_reg, hde_next;
    logic [5:0] bc_reg, bc_next;
    logic bp_reg, bp_next;
    logic [7:0] rd;
    logic [5:0] ra;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++) regs_reg[i] <= '0;
            regs_reg[16] <= R16_RESET;
            regs_reg[17] <= R17_RESET;
            sel_reg <= '0; hc_reg <= '0; rc_reg <= '0; lc_reg <= '0; adj_reg <= '0;
            ma_reg <= '0; ls_reg <= '0; hsc_reg <= '0; hsw_reg <= '0;
            vsc_reg <= '0; vsw_reg <= 5'd16;
            f_htot_reg <= 1'b0; f_vtot_reg <= 1'b0; f_mr_reg <= 1'b0;
            f_vadj_reg <= 1'b0; f_vdisp_reg <= 1'b0; f_hdisp_reg <= 1'b0;
            f_r8dt_reg <= 1'b0; f_vscnt_reg <= 1'b1; f_hs_reg <= 1'b0;
            f_vs_reg <= 1'b0; f_ilace_reg <= 1'b0;
            hlvs_reg <= 1'b0; par_reg <= 1'b0; vsl_reg <= 1'b1;
            skew_reg <= '0; hds_reg <= '0; hde_reg <= '0; bc_reg <= '0; bp_reg <= 1'b0;
            result <= '0;
        end
        else if (step)
        begin
            regs_reg <= regs_next;
            sel_reg <= sel_next; hc_reg <= hc_next; rc_reg <= rc_next;
            lc_reg <= lc_next; adj_reg <= adj_next; ma_reg <= ma_next; ls_reg <= ls_next;
            hsc_reg <= hsc_next; hsw_reg <= hsw_next; vsc_reg <= vsc_next; vsw_reg <= vsw_next;
            f_htot_reg <= f_htot_next; f_vtot_reg <= f_vtot_next; f_mr_reg <= f_mr_next;
            f_vadj_reg <= f_vadj_next; f_vdisp_reg <= f_vdisp_next;
            f_hdisp_reg <= f_hdisp_next; f_r8dt_reg <= f_r8dt_next;
            f_vscnt_reg <= f_vscnt_next; f_hs_reg <= f_hs_next; f_vs_reg <= f_vs_next;
            f_ilace_reg <= f_ilace_next;
            hlvs_reg <= hlvs_next; par_reg <= par_next; vsl_reg <= vsl_next;
            skew_reg <= skew_next; hds_reg <= hds_next; hde_reg <= hde_next;
            bc_reg <= bc_next; bp_reg <= bp_next;
            result.read_data      <= rd;
            result.hsync_out      <= f_hs_next;
            result.vsync_out      <= vsl_next;
            result.display_enable <= f_hdisp_next & f_vdisp_next & ~f_r8dt_next;
            result.mem_address    <= ma_next;
            result.row_address    <= ra;
            result.cursor_blink   <= bp_next;
        end
    end

    // next state for one word
    always_comb
    begin
        logic [4:0] idx;
        logic [7:0] val;
        logic [3:0] w;
        logic       vs_before;
        logic [1:0] d;
        logic [5:0] period;
        regs_next = regs_reg;
        sel_next = sel_reg; hc_next = hc_reg; rc_next = rc_reg; lc_next = lc_reg;
        adj_next = adj_reg; ma_next = ma_reg; ls_next = ls_reg;
        hsc_next = hsc_reg; hsw_next = hsw_reg; vsc_next = vsc_reg; vsw_next = vsw_reg;
        f_htot_next = f_htot_reg; f_vtot_next = f_vtot_reg; f_mr_next = f_mr_reg;
        f_vadj_next = f_vadj_reg; f_vdisp_next = f_vdisp_reg; f_hdisp_next = f_hdisp_reg;
        f_r8dt_next = f_r8dt_reg; f_vscnt_next = f_vscnt_reg; f_hs_next = f_hs_reg;
        f_vs_next = f_vs_reg; f_ilace_next = f_ilace_reg;
        hlvs_next = hlvs_reg; par_next = par_reg; vsl_next = vsl_reg;
        skew_next = skew_reg; hds_next = hds_reg; hde_next = hde_reg;
        bc_next = bc_reg; bp_next = bp_reg;
        rd = '0;
        idx = sel_reg;
        val = '0;
        w = '0;
        vs_before = 1'b0;
        d = '0;
        period = '0;

        case (req_t'(word.req_type))
            REQ_SELECT: sel_next = word.bus_data[4:0];
            REQ_READ:
            begin
                if (readable(idx)) rd = regs_reg[idx];
            end
            REQ_WRITE:
            begin
                if (idx < 5'(NUM_REGS))
                begin
                    val = word.bus_data & wr_mask(idx);
                    regs_next[idx] = val;
                    if (idx == R_HDISP)
                    begin
                        hde_next = val + {6'd0, skew_reg};
                        hds_next = {6'd0, skew_reg};
                        if (val == 8'd0) begin hds_next = '0; hde_next = '0; end
                    end
                    if (idx == R_VADJ || idx == R_VDISP)
                    begin
                        if ({1'b0, lc_reg} == regs_next[6]) f_vdisp_next = 1'b0;
                        if (lc_reg == '0 && rc_reg == '0 && regs_next[6] != 8'd0)
                            f_vdisp_next = 1'b1;
                    end
                    if (idx == R_VSPOS && {1'b0, lc_reg} == val && hc_reg != '0
                        && !f_vscnt_reg)
                    begin
                        w = regs_reg[3][7:4];
                        vsc_next = '0;
                        vsw_next = (w != '0) ? {1'b0, w} : 5'd16;
                        f_vscnt_next = 1'b1;
                        vsl_next = 1'b1;
                    end
                    if (idx == R_MODE)
                    begin
                        d = val[5:4];
                        f_r8dt_next = (d == 2'd3);
                        skew_next = (d == 2'd3) ? 2'd0 : d;
                        hde_next = regs_reg[1] + {6'd0, skew_next};
                        hds_next = {6'd0, skew_next};
                        if (regs_reg[1] == 8'd0) begin hds_next = '0; hde_next = '0; end
                    end
                    if (idx == R_MAXRAS)
                    begin
                        if (f_vadj_reg) f_mr_next = ({3'd0, adj_reg} == val);
                        else f_mr_next = ({3'd0, rc_reg} == val);
                    end
                end
            end
            REQ_TICK:
            begin
                hc_next = hc_reg + 8'd1;
                ma_next = (ma_reg + 14'd1) & ADDR_MASK;
                if (f_htot_reg)
                begin
                    vs_before = f_vscnt_reg;
                    f_htot_next = 1'b0;
                    hc_next = '0;
                    // end of a scan line
                    rc_next = rc_reg + 5'd1;
                    if (f_vscnt_next)
                    begin
                        vsc_next = vsc_reg + 5'd1;
                        if (vsc_next == vsw_reg)
                        begin
                            vsc_next = '0;
                            f_vscnt_next = 1'b0;
                        end
                    end
                    for (int k = 0; k < 2; k++)
                    begin
                        // k=0: adjust stage, k=1: restart after max raster
                        if (k == 0 && f_vadj_next)
                        begin
                            adj_next = adj_reg + 5'd1;
                            if ({3'd0, adj_next} == regs_reg[5])
                            begin
                                f_vadj_next = 1'b0;
                                ls_next = {regs_reg[12][5:0], regs_reg[13]};
                                rc_next = '0; lc_next = '0; f_vdisp_next = 1'b1;
                                bc_next = bc_next + 6'd1;
                                if (regs_reg[10][6])
                                begin
                                    period = regs_reg[10][5] ? 6'd32 : 6'd16;
                                    if (bc_next == period)
                                    begin
                                        bc_next = '0;
                                        bp_next = ~bp_next;
                                    end
                                end
                                else bp_next = ~regs_reg[10][5];
                            end
                        end
                        if (k == 1 && f_mr_reg)
                        begin
                            f_mr_next = 1'b0;
                            rc_next = '0;
                            if (f_vtot_reg)
                            begin
                                f_vtot_next = 1'b0;
                                par_next = ~par_reg;
                                if (regs_reg[5] != 8'd0)
                                begin
                                    adj_next = '0;
                                    f_vadj_next = 1'b1;
                                    lc_next = lc_next + 7'd1;
                                end
                                else
                                begin
                                    ls_next = {regs_reg[12][5:0], regs_reg[13]};
                                    rc_next = '0; lc_next = '0; f_vdisp_next = 1'b1;
                                    bc_next = bc_next + 6'd1;
                                    if (regs_reg[10][6])
                                    begin
                                        period = regs_reg[10][5] ? 6'd32 : 6'd16;
                                        if (bc_next == period)
                                        begin
                                            bc_next = '0;
                                            bp_next = ~bp_next;
                                        end
                                    end
                                    else bp_next = ~regs_reg[10][5];
                                end
                            end
                            else if (!f_vadj_next) lc_next = lc_next + 7'd1;
                        end
                    end
                    ma_next = ls_next;
                    f_ilace_next = regs_reg[8][0];
                    if (f_ilace_next)
                    begin
                        if (regs_reg[8][1])
                            f_mr_next = ({3'd0, rc_next} == {1'b0, regs_reg[9][7:1]});
                    end
                    else if (f_vadj_next)
                    begin
                        if ({3'd0, adj_next} == regs_reg[9]) f_mr_next = 1'b1;
                    end
                    else if ({3'd0, rc_next} == regs_reg[9]) f_mr_next = 1'b1;
                    if (f_mr_next && {1'b0, lc_next} == regs_reg[4]) f_vtot_next = 1'b1;
                    if ({1'b0, lc_next} == regs_reg[6]) f_vdisp_next = 1'b0;
                    if ({1'b0, lc_next} == regs_reg[7] && !f_vscnt_next)
                    begin
                        w = regs_reg[3][7:4];
                        vsc_next = '0;
                        vsw_next = (w != '0) ? {1'b0, w} : 5'd16;
                        f_vscnt_next = 1'b1;
                        vsl_next = 1'b1;
                    end
                    if (vs_before != f_vscnt_next)
                    begin
                        f_vs_next = f_vscnt_next;
                        hlvs_next = f_vscnt_next;
                        vsl_next = f_vscnt_next;
                    end
                end
                if (hc_next == regs_reg[0]) f_htot_next = 1'b1;
                if (hc_next == {1'b0, regs_reg[0][7:1]}) f_vs_next = hlvs_next;
                // horizontal sync width counter
                if (f_hs_reg)
                begin
                    hsc_next = hsc_reg + 4'd1;
                    if (hsc_next == hsw_reg)
                    begin
                        hsc_next = '0;
                        f_hs_next = 1'b0;
                    end
                end
                if (hc_next == regs_reg[2])
                begin
                    hsw_next = regs_reg[3][3:0];
                    if (hsw_next != '0 && !f_hs_next)
                    begin
                        f_hs_next = 1'b1;
                        hsc_next = '0;
                    end
                end
                // horizontal display window
                if (hc_next == hds_reg) f_hdisp_next = 1'b1;
                if (hc_next == hde_reg) f_hdisp_next = 1'b0;
                if (hc_next == regs_reg[1])
                begin
                    f_hdisp_next = 1'b0;
                    if (f_mr_next && f_vdisp_next) ls_next = ma_next;
                end
            end
            default: ;
        endcase

        if (f_ilace_next) ra = {rc_next, par_next};
        else if (f_vadj_next) ra = {1'b0, adj_next};
        else ra = {1'b0, rc_next};
    end

    // the result register tracks the refresh address
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result.mem_address == ma_reg)
        else $error("memory address out of step");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && word.req_type != REQ_TICK |=> hc_reg == $past(hc_reg))
        else $error("horizontal counter moved without a tick");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && word.req_type != REQ_READ |=> result.read_data == 8'd0)
        else $error("read data not zero outside a read");
    assert property (@(posedge clk) disable iff (!rst_n)
        result.display_enable |-> !f_r8dt_reg)
        else $error("display enable while skew disables");
endmodule

// File: design/crt_controller_timing.sv
// top level of the crt controller timing block: handshake and output register
//  channel | direction | word type   | handshake
//  in      | input     | in_word_t   | in_valid / in_ready
//  out     | output    | out_word_t  | out_valid / out_ready
// results are registered; one word can enter each clock unless input stalls
// the result register holds one word; input stalls only while it is full and not taken
// reset puts the registers in their power-up values and clears out_valid
module crt_controller_timing (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crtc_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output crtc_pkg::out_word_t out_data
);
    import crtc_pkg::*;

    logic valid_reg;
    logic step;

    // accept when the result slot is free or being drained
    assign in_ready  = !valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (in_ready) valid_reg <= in_valid;
    end

    crtc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_data),
        .result (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(out_data))
        else $error("result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> valid_reg)
        else $error("accepted word produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty slot refused input");
endmodule

// File: tb/sv/crt_controller_timing_checker.sv
// checker for the crt controller timing block: timing predictor and result compare
`timescale 1ns / 100ps

module crt_controller_timing_checker
    import crtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    output int        fail_count,
    output int        pending
);

    // status flag bits
    localparam logic [11:0] FL_HTOT  = 12'h001;
    localparam logic [11:0] FL_VTOT  = 12'h002;
    localparam logic [11:0] FL_MR    = 12'h004;
    localparam logic [11:0] FL_VADJ  = 12'h008;
    localparam logic [11:0] FL_VDISP = 12'h010;
    localparam logic [11:0] FL_HDISP = 12'h020;
    localparam logic [11:0] FL_R8DT  = 12'h040;
    localparam logic [11:0] FL_VSCNT = 12'h080;
    localparam logic [11:0] FL_HS    = 12'h100;
    localparam logic [11:0] FL_VS    = 12'h200;
    localparam logic [11:0] FL_ILACE = 12'h400;

    logic [7:0]  regs [NUM_REGS];
    logic [4:0]  sel;
    logic [7:0]  hcnt;
    logic [4:0]  rcnt;
    logic [6:0]  lcnt;
    logic [4:0]  acnt;
    logic [13:0] ma, ma_line;
    logic [4:0]  hs_cnt, hs_wid, vs_cnt, vs_wid;
    logic [11:0] flags;
    logic        half_vs, parity;
    logic [1:0]  skew;
    logic [7:0]  hd_start, hd_end;
    logic [5:0]  blink_cnt;
    logic        blink, vs_line;

    out_word_t   expected_words[$];

    function automatic logic fl(logic [11:0] f);
        return (flags & f) != 0;
    endfunction

    function automatic void set_fl(logic [11:0] f, logic on);
        if (on) flags = flags | f;
        else flags = flags & ~f;
    endfunction

    function automatic void update_hdisp();
        hd_end = regs[1] + {6'd0, skew};
        hd_start = {6'd0, skew};
        if (regs[1] == 0) begin
            hd_start = 0;
            hd_end = 0;
        end
    endfunction

    function automatic void start_vsync();
        logic [3:0] w;
        if (!fl(FL_VSCNT)) begin
            w = regs[3][7:4];
            vs_cnt = 0;
            vs_wid = (w != 0) ? {1'b0, w} : 5'd16;
            set_fl(FL_VSCNT, 1'b1);
            vs_line = 1'b1;
        end
    endfunction

    function automatic void new_frame();
        logic [5:0] period;
        ma_line = {regs[12][5:0], regs[13]};
        ma = ma_line;
        rcnt = 0;
        lcnt = 0;
        set_fl(FL_VDISP, 1'b1);
        blink_cnt = blink_cnt + 6'd1;
        if (regs[10][6]) begin
            period = regs[10][5] ? 6'd32 : 6'd16;
            if (blink_cnt == period) begin
                blink_cnt = 0;
                blink = ~blink;
            end
        end else begin
            blink = ~regs[10][5];
        end
    endfunction

    // end of scan line: raster, line, adjust and vsync counters
    function automatic void next_line();
        rcnt = rcnt + 5'd1;
        if (fl(FL_VSCNT)) begin
            vs_cnt = vs_cnt + 5'd1;
            if (vs_cnt == vs_wid) begin
                vs_cnt = 0;
                set_fl(FL_VSCNT, 1'b0);
            end
        end
        if (fl(FL_VADJ)) begin
            acnt = acnt + 5'd1;
            if ({3'd0, acnt} == regs[5]) begin
                set_fl(FL_VADJ, 1'b0);
                new_frame();
            end
        end
        if (fl(FL_MR)) begin
            set_fl(FL_MR, 1'b0);
            rcnt = 0;
            if (fl(FL_VTOT)) begin
                set_fl(FL_VTOT, 1'b0);
                parity = ~parity;
                if (regs[5] != 0) begin
                    acnt = 0;
                    set_fl(FL_VADJ, 1'b1);
                    lcnt = lcnt + 7'd1;
                end else begin
                    new_frame();
                end
            end else if (!fl(FL_VADJ)) begin
                lcnt = lcnt + 7'd1;
            end
        end
        ma = ma_line;
        set_fl(FL_ILACE, regs[8][0]);
        if (fl(FL_ILACE)) begin
            if (regs[8][1]) set_fl(FL_MR, {3'd0, rcnt} == (regs[9] >> 1));
        end else if (fl(FL_VADJ)) begin
            if ({3'd0, acnt} == regs[9]) set_fl(FL_MR, 1'b1);
        end else begin
            if ({3'd0, rcnt} == regs[9]) set_fl(FL_MR, 1'b1);
        end
        if (fl(FL_MR) && {1'b0, lcnt} == regs[4]) set_fl(FL_VTOT, 1'b1);
        if ({1'b0, lcnt} == regs[6]) set_fl(FL_VDISP, 1'b0);
        if ({1'b0, lcnt} == regs[7]) start_vsync();
    endfunction

    // one character clock
    function automatic void char_tick();
        logic [11:0] prev;
        hcnt = hcnt + 8'd1;
        ma = ma + 14'd1;
        if (fl(FL_HTOT)) begin
            prev = flags;
            set_fl(FL_HTOT, 1'b0);
            hcnt = 0;
            next_line();
            if (((prev ^ flags) & FL_VSCNT) != 0) begin
                set_fl(FL_VS, fl(FL_VSCNT));
                half_vs = fl(FL_VSCNT);
                vs_line = fl(FL_VSCNT);
            end
        end
        if (hcnt == regs[0]) set_fl(FL_HTOT, 1'b1);
        if (hcnt == (regs[0] >> 1)) set_fl(FL_VS, half_vs);
        if (fl(FL_HS)) begin
            hs_cnt = {1'b0, hs_cnt[3:0] + 4'd1};
            if (hs_cnt == hs_wid) begin
                hs_cnt = 0;
                set_fl(FL_HS, 1'b0);
            end
        end
        if (hcnt == regs[2]) begin
            hs_wid = {1'b0, regs[3][3:0]};
            if (hs_wid != 0 && !fl(FL_HS)) begin
                set_fl(FL_HS, 1'b1);
                hs_cnt = 0;
            end
        end
        if (hcnt == hd_start) set_fl(FL_HDISP, 1'b1);
        if (hcnt == hd_end) set_fl(FL_HDISP, 1'b0);
        if (hcnt == regs[1]) begin
            set_fl(FL_HDISP, 1'b0);
            if (fl(FL_MR) && fl(FL_VDISP)) ma_line = ma;
        end
    endfunction

    function automatic void reg_write(logic [7:0] val);
        logic [1:0] d;
        if (sel >= NUM_REGS) return;
        regs[sel] = val & wr_mask(sel);
        case (sel)
            R_HDISP: update_hdisp();
            R_VADJ, R_VDISP: begin
                if ({1'b0, lcnt} == regs[6]) set_fl(FL_VDISP, 1'b0);
                if (lcnt == 0 && rcnt == 0 && regs[6] != 0) set_fl(FL_VDISP, 1'b1);
            end
            R_VSPOS: if ({1'b0, lcnt} == regs[7] && hcnt != 0) start_vsync();
            R_MODE: begin
                d = regs[8][5:4];
                set_fl(FL_R8DT, d == 2'd3);
                skew = (d == 2'd3) ? 2'd0 : d;
                update_hdisp();
            end
            R_MAXRAS: begin
                if (fl(FL_VADJ)) set_fl(FL_MR, {3'd0, acnt} == regs[9]);
                else set_fl(FL_MR, {3'd0, rcnt} == regs[9]);
            end
            default: ;
        endcase
    endfunction

    function automatic out_word_t predict_word(in_word_t w);
        out_word_t r;
        r = '0;
        case (req_t'(w.req_type))
            REQ_SELECT: sel = w.bus_data[4:0];
            REQ_WRITE:  reg_write(w.bus_data);
            REQ_READ:   if (sel < NUM_REGS && readable(sel)) r.read_data = regs[sel];
            default:    char_tick();
        endcase
        if (fl(FL_ILACE)) r.row_address = {rcnt, parity};
        else if (fl(FL_VADJ)) r.row_address = {1'b0, acnt};
        else r.row_address = {1'b0, rcnt};
        r.hsync_out = fl(FL_HS);
        r.vsync_out = vs_line;
        r.display_enable = (flags & (FL_HDISP | FL_VDISP | FL_R8DT)) == (FL_HDISP | FL_VDISP);
        r.mem_address = ma;
        r.cursor_blink = blink;
        return r;
    endfunction

    // predict on accepted input word, compare on accepted output word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
            regs[16] = R16_RESET;
            regs[17] = R17_RESET;
            sel = 0; hcnt = 0; rcnt = 0; lcnt = 0; acnt = 0;
            ma = 0; ma_line = 0;
            hs_cnt = 0; hs_wid = 0; vs_cnt = 0; vs_wid = 5'd16;
            flags = FL_VSCNT;
            half_vs = 0; parity = 0; skew = 0;
            hd_start = 0; hd_end = 0; blink_cnt = 0; blink = 0; vs_line = 1;
            expected_words.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            out_word_t want;
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word %h", out_data);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want !== out_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_word(in_data));
            pending = expected_words.size();
        end
    end

endmodule

// File: tb/sv/crt_controller_timing_tb.sv
// top of the crt controller timing testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module crt_controller_timing_tb;
    import crtc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    int        fail_count;
    int        pending;
    logic      quiet;

    crt_controller_timing DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    crt_controller_timing_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("crt_controller_timing test failed");
        $finish;
    end

    // output stalls in random bursts
    initial
    begin
        int n;
        out_ready = 1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 10);
                out_ready = 0;
                repeat (n) @(negedge clk);
                out_ready = 1;
            end
        end
    end

    // present one word, hold it until accepted
    task automatic send_word(req_t kind, logic [7:0] data);
        in_valid = 1;
        in_data.req_type = kind;
        in_data.bus_data = data;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic put_reg(logic [4:0] idx, logic [7:0] val);
        send_word(REQ_SELECT, {3'd0, idx});
        send_word(REQ_WRITE, val);
    endtask

    task automatic ticks(int n);
        repeat (n) send_word(REQ_TICK, 8'($urandom));
    endtask

    // small well-formed frame setup with random content
    task automatic small_frame();
        put_reg(0, 8'($urandom_range(3, 12)));
        put_reg(1, 8'($urandom_range(0, 8)));
        put_reg(2, 8'($urandom_range(0, 10)));
        put_reg(3, 8'($urandom));
        put_reg(4, 8'($urandom_range(0, 4)));
        put_reg(5, 8'($urandom_range(0, 3)));
        put_reg(6, 8'($urandom_range(0, 4)));
        put_reg(7, 8'($urandom_range(0, 4)));
        put_reg(8, 8'($urandom));
        put_reg(9, 8'($urandom_range(0, 3)));
        put_reg(10, 8'($urandom));
    endtask

    initial
    begin
        int k;
        quiet = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: every register read/write, extremes, wide/zero sync widths
        for (int r = 0; r < 32; r += 1)
        begin
            send_word(REQ_SELECT, (r == 31) ? 8'hff : r[7:0]);
            send_word(REQ_WRITE, (r % 2) ? 8'hff : 8'h00);
            send_word(REQ_READ, 8'h00);
        end
        put_reg(0, 8'd5); put_reg(3, 8'h00); put_reg(9, 8'd1); put_reg(4, 8'd1);
        ticks(40);
        put_reg(3, 8'hff); put_reg(8, 8'h33); put_reg(10, 8'h60);
        ticks(60);

        // random: mostly ticks, some small frames and noise
        for (k = 0; k < 75; k++)
        begin
            if (k > 62) quiet = 1;
            case ($urandom_range(0, 19))
                0: small_frame();
                1: send_word(REQ_SELECT, 8'($urandom));
                2: send_word(REQ_WRITE, 8'($urandom));
                3: send_word(REQ_READ, 8'($urandom));
                4: put_reg(5'($urandom_range(0, 17)), 8'($urandom));
                default: ticks($urandom_range(1, 4));
            endcase
        end
        in_valid = 0;

        while (pending != 0 || out_valid) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("crt_controller_timing test passed");
        else
            $display("crt_controller_timing test failed");
        $finish;
    end

endmodule

// File: files.f
design/crtc_pkg.sv
design/crtc_core.sv
design/crt_controller_timing.sv
tb/sv/crt_controller_timing_checker.sv
tb/sv/crt_controller_timing_tb.sv
